FILE: rtl/hex_ascii_packet_deframer_crc16_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hex-ASCII packet deframer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef HEX_ASCII_PACKET_DEFRAMER_CRC16_TOP_DEFINES_SVH
`define HEX_ASCII_PACKET_DEFRAMER_CRC16_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check on every clk edge outside reset.
`define HAPD_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clk edge, reset included.
`define HAPD_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HAPD_ASSERT_RUN(label, prop, msg)
`define HAPD_ASSERT_ALL(label, prop, msg)
`endif

`endif

FILE: rtl/hapd_pkg.sv
// ---------------------------------------------------------------------------
// hapd_pkg
// Types, codes, frame bytes and CRC/hex helpers for the packet deframer.
// ---------------------------------------------------------------------------
package hapd_pkg;

  localparam int unsigned TRAILER_BYTES_DEF = 5;
  localparam int unsigned MIN_FRAME_LEN     = 10;
  localparam int unsigned MAX_FRAME_LEN     = 32767;

  localparam logic [14:0] MAX_LENGTH_RESET = 15'd3000;
  localparam logic [6:0]  SEQ_RESET        = 7'h21;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  localparam logic [7:0] BYTE_SOH  = 8'h01;
  localparam logic [7:0] BYTE_STX  = 8'h02;
  localparam logic [7:0] BYTE_ETB  = 8'h17;
  localparam logic [7:0] BYTE_ETX  = 8'h03;
  localparam logic [8:0] ECHO_FLAG = 9'h080;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_FRAME    = 3'd1,
    STATUS_CRC      = 3'd2,
    STATUS_SEQUENCE = 3'd3,
    STATUS_ECHO     = 3'd4,
    STATUS_HEX      = 3'd5,
    STATUS_OVERFLOW = 3'd6
  } status_t;

  typedef struct packed {
    logic       op;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [13:0] payload_count;
  } res_t;

  // Result hand-off from the frame receiver to the output buffer.
  typedef struct packed {
    logic push;
    res_t data;
  } res_push_t;

  // One byte through CRC-16, reflected polynomial, LSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Bit 4 set for an uppercase hex character, low bits the nibble.
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (ch >= 8'h41 && ch <= 8'h46) begin
      d = ch - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

endpackage

FILE: rtl/hapd_stream_if.sv
// ---------------------------------------------------------------------------
// hapd_stream_if
// Valid/ready channel with a typed payload.
// ---------------------------------------------------------------------------
interface hapd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/hapd_frame_rx.sv
// ---------------------------------------------------------------------------
// hapd_frame_rx
// Frame checker: header capture, trailer delay line, CRC, hex decode, status.
// ---------------------------------------------------------------------------
module hapd_frame_rx #(
  parameter int unsigned TRAILER_BYTES = hapd_pkg::TRAILER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  hapd_stream_if.sink         item,
  hapd_stream_if.sink         cfg,
  input  logic                space,
  output hapd_pkg::res_push_t res
);

  localparam logic [14:0] FULL_POS = 15'(4 + TRAILER_BYTES);

  logic        active, active_next;
  logic [6:0]  seq_num, seq_num_next;
  logic [7:0]  exp_cmd, exp_cmd_next;
  logic [14:0] byte_pos, byte_pos_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  trail [TRAILER_BYTES];
  logic [7:0]  trail_next [TRAILER_BYTES];
  logic [7:0]  hdr_soh, hdr_soh_next;
  logic [7:0]  hdr_stx, hdr_stx_next;
  logic [7:0]  hdr_echo, hdr_echo_next;
  logic [7:0]  number_byte, number_byte_next;
  logic [4:0]  hex_hi, hex_hi_next;
  logic        hex_err, hex_err_next;
  logic [13:0] dec_cnt, dec_cnt_next;
  logic [14:0] max_length;

  logic        take;
  logic [7:0]  b;
  logic [15:0] cnt;
  logic [7:0]  seq_inc;
  logic [4:0]  hv;

  assign item.ready = space;
  assign cfg.ready  = 1'b1;
  assign take       = item.valid && item.ready;
  assign b          = item.data.value;
  assign cnt        = {1'b0, byte_pos} + 16'd1;
  assign seq_inc    = {1'b0, seq_num} + 8'd1;
  assign hv         = hapd_pkg::hex_decode(trail[0]);

  always_comb begin
    active_next      = active;
    seq_num_next     = seq_num;
    exp_cmd_next     = exp_cmd;
    byte_pos_next    = byte_pos;
    crc_next         = crc;
    trail_next       = trail;
    hdr_soh_next     = hdr_soh;
    hdr_stx_next     = hdr_stx;
    hdr_echo_next    = hdr_echo;
    number_byte_next = number_byte;
    hex_hi_next      = hex_hi;
    hex_err_next     = hex_err;
    dec_cnt_next     = dec_cnt;
    res              = '0;

    if (take) begin
      if (item.data.op == hapd_pkg::OP_START) begin
        // Arm: drop any packet in progress.
        active_next      = 1'b1;
        exp_cmd_next     = b;
        byte_pos_next    = '0;
        crc_next         = '0;
        for (int i = 0; i < TRAILER_BYTES; i++) trail_next[i] = '0;
        hdr_soh_next     = '0;
        hdr_stx_next     = '0;
        hdr_echo_next    = '0;
        number_byte_next = '0;
        hex_hi_next      = '0;
        hex_err_next     = 1'b0;
        dec_cnt_next     = '0;
      end else if (active) begin
        if (b == hapd_pkg::BYTE_ETX) begin
          active_next     = 1'b0;
          res.push        = 1'b1;
          res.data.kind   = hapd_pkg::KIND_END;
          if (cnt < 16'(hapd_pkg::MIN_FRAME_LEN) || cnt > 16'(hapd_pkg::MAX_FRAME_LEN) ||
              hdr_soh != hapd_pkg::BYTE_SOH || hdr_stx != hapd_pkg::BYTE_STX ||
              trail[0] != hapd_pkg::BYTE_ETB) begin
            res.data.status = hapd_pkg::STATUS_FRAME;
          end else if (trail[1] != hapd_pkg::hex_char(crc[7:4]) ||
                       trail[2] != hapd_pkg::hex_char(crc[3:0]) ||
                       trail[3] != hapd_pkg::hex_char(crc[15:12]) ||
                       trail[4] != hapd_pkg::hex_char(crc[11:8])) begin
            res.data.status = hapd_pkg::STATUS_CRC;
          end else if (number_byte != {1'b0, seq_num}) begin
            res.data.status = hapd_pkg::STATUS_SEQUENCE;
          end else begin
            seq_num_next = seq_inc[7] ? hapd_pkg::SEQ_RESET : seq_inc[6:0];
            if ({1'b0, exp_cmd} + hapd_pkg::ECHO_FLAG != {1'b0, hdr_echo}) begin
              res.data.status = hapd_pkg::STATUS_ECHO;
            end else if (hex_err || dec_cnt == 14'd0) begin
              res.data.status = hapd_pkg::STATUS_HEX;
            end else begin
              res.data.status        = hapd_pkg::STATUS_OK;
              res.data.payload_count = dec_cnt;
            end
          end
        end else if (cnt > {1'b0, max_length}) begin
          active_next     = 1'b0;
          res.push        = 1'b1;
          res.data.kind   = hapd_pkg::KIND_END;
          res.data.status = hapd_pkg::STATUS_OVERFLOW;
        end else begin
          byte_pos_next = cnt[14:0];
          if (byte_pos == 15'd0) begin
            hdr_soh_next = b;
          end else if (byte_pos == 15'd1) begin
            number_byte_next = b;
            crc_next         = hapd_pkg::crc16_step(crc, b);
          end else if (byte_pos == 15'd2) begin
            hdr_stx_next = b;
          end else if (byte_pos == 15'd3) begin
            hdr_echo_next = b;
            crc_next      = hapd_pkg::crc16_step(crc, b);
          end else begin
            // Advance the delay line; the byte leaving it is payload.
            for (int i = 0; i < TRAILER_BYTES - 1; i++) trail_next[i] = trail[i + 1];
            trail_next[TRAILER_BYTES - 1] = b;
            if (byte_pos >= FULL_POS) begin
              crc_next = hapd_pkg::crc16_step(crc, trail[0]);
              if (!hex_err) begin
                if (hex_hi == 5'd0) begin
                  hex_hi_next = hv[4] ? hv : 5'd1;
                end else if (hex_hi == 5'd1 || !hv[4]) begin
                  hex_err_next = 1'b1;
                  hex_hi_next  = 5'd0;
                end else begin
                  res.push              = 1'b1;
                  res.data.kind         = hapd_pkg::KIND_PAYLOAD;
                  res.data.payload_byte = {hex_hi[3:0], hv[3:0]};
                  res.data.status       = hapd_pkg::STATUS_OK;
                  hex_hi_next           = 5'd0;
                  dec_cnt_next          = dec_cnt + 14'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      seq_num     <= hapd_pkg::SEQ_RESET;
      exp_cmd     <= '0;
      byte_pos    <= '0;
      crc         <= '0;
      for (int i = 0; i < TRAILER_BYTES; i++) trail[i] <= '0;
      hdr_soh     <= '0;
      hdr_stx     <= '0;
      hdr_echo    <= '0;
      number_byte <= '0;
      hex_hi      <= '0;
      hex_err     <= 1'b0;
      dec_cnt     <= '0;
      max_length  <= hapd_pkg::MAX_LENGTH_RESET;
    end else begin
      active      <= active_next;
      seq_num     <= seq_num_next;
      exp_cmd     <= exp_cmd_next;
      byte_pos    <= byte_pos_next;
      crc         <= crc_next;
      trail       <= trail_next;
      hdr_soh     <= hdr_soh_next;
      hdr_stx     <= hdr_stx_next;
      hdr_echo    <= hdr_echo_next;
      number_byte <= number_byte_next;
      hex_hi      <= hex_hi_next;
      hex_err     <= hex_err_next;
      dec_cnt     <= dec_cnt_next;
      if (cfg.valid && cfg.ready) begin
        max_length <= cfg.data;
      end
    end
  end

endmodule

FILE: rtl/hapd_out_buf.sv
// ---------------------------------------------------------------------------
// hapd_out_buf
// Two-entry result buffer between the frame receiver and the result channel.
// ---------------------------------------------------------------------------
module hapd_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  hapd_pkg::res_push_t res,
  output logic                space,
  hapd_stream_if.source       result
);

  logic [1:0]     cnt, cnt_next;
  hapd_pkg::res_t ent0, ent1;
  logic           pop;

  assign pop          = result.valid && result.ready;
  assign space        = (cnt != 2'd2);
  assign result.valid = (cnt != 2'd0);
  assign result.data  = ent0;
  assign cnt_next     = cnt + {1'b0, res.push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        ent0 <= ent1;
      end else if (res.push) begin
        ent0 <= res.data;
      end
    end else if (res.push) begin
      if (cnt == 2'd0) begin
        ent0 <= res.data;
      end else begin
        ent1 <= res.data;
      end
    end
  end

endmodule

FILE: rtl/hex_ascii_packet_deframer_crc16_top.sv
// ---------------------------------------------------------------------------
// hex_ascii_packet_deframer_crc16_top
// Framed packet receiver: hex-ASCII payload, CRC-16 (0xA001) trailer check.
// ---------------------------------------------------------------------------
//
//  channel   dir  payload                                        handshake
//  -------   ---  ---------------------------------------------  ---------
//  item      in   op (1), value (8)                              valid/ready
//  result    out  kind (1), payload_byte (8), status (3),        valid/ready
//                 payload_count (14)
//  cfg       in   max_length (15)                                valid/ready
//
//  One item per cycle while item.ready is high; its result, if any, is
//  computed combinationally from the frame state registers and written
//  into the two-entry result buffer with the item transaction.
//  item.ready drops only while two results wait in the buffer.
//  cfg.ready is always high; write max_length only while idle.
//  rst (synchronous) clears the packet state, sets sequence 0x21 and
//  max_length 3000, and empties the buffer.
// ---------------------------------------------------------------------------
`include "hex_ascii_packet_deframer_crc16_top_defines.svh"

module hex_ascii_packet_deframer_crc16_top #(
  parameter int unsigned TRAILER_BYTES = hapd_pkg::TRAILER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  hapd_stream_if.sink   item,
  hapd_stream_if.source result,
  hapd_stream_if.sink   cfg
);

  // Result from the frame checker, pushed into the buffer in the same cycle.
  hapd_pkg::res_push_t res;
  // Buffer has room for one more result: gate item transactions on it.
  logic                space;

  // Check framing, CRC and hex; produce one result per item at most.
  hapd_frame_rx #(
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_frame_rx (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cfg   (cfg),
    .space (space),
    .res   (res)
  );

  // Hold results until the consumer takes them.
  hapd_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .space  (space),
    .result (result)
  );

  // Stall the input only when results are backed up.
  `HAPD_ASSERT_RUN(a_stall_only_when_backed_up, !item.ready |-> result.valid, "input stalled with empty buffer")

  // A failed packet never reports a count.
  `HAPD_ASSERT_RUN(a_fail_no_count, result.valid && result.data.kind == hapd_pkg::KIND_END && result.data.status != hapd_pkg::STATUS_OK |-> result.data.payload_count == 14'd0, "count on failed packet")

  // Payload results carry neutral status and count fields.
  `HAPD_ASSERT_RUN(a_payload_fields, result.valid && result.data.kind == hapd_pkg::KIND_PAYLOAD |-> result.data.status == hapd_pkg::STATUS_OK && result.data.payload_count == 14'd0, "payload result with status or count")

  // Drop everything on reset.
  `HAPD_ASSERT_ALL(a_reset_empty, rst |=> !result.valid, "result valid after reset")

endmodule

FILE: verif/tb_hex_ascii_packet_deframer_crc16_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hex_ascii_packet_deframer_crc16_top
// Self-checking bench for the framed hex-ASCII packet receiver. A local
// model of the frame checker predicts every payload byte and end status;
// a monitor compares each result transaction against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_hex_ascii_packet_deframer_crc16_top;

  localparam int TRAILER          = hapd_pkg::TRAILER_BYTES_DEF;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int DRAIN_LIMIT      = 50_000;
  localparam int SETTLE           = 4;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS     = 40;

  typedef logic [7:0] octet_q_t[$];

  // Flavors of random line traffic.
  typedef enum int {
    TRAFFIC_GOOD,
    TRAFFIC_MUTATED,
    TRAFFIC_BAD_HEADER,
    TRAFFIC_TRUNCATED,
    TRAFFIC_BAD_TEXT,
    TRAFFIC_NOISE
  } traffic_t;

  logic clk;
  logic rst;

  hapd_stream_if #(.T(hapd_pkg::item_t)) item_if ();
  hapd_stream_if #(.T(hapd_pkg::res_t))  result_if ();
  hapd_stream_if #(.T(logic [14:0]))     cfg_if ();

  hex_ascii_packet_deframer_crc16_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // Receiver model state, kept at the block's widths but for the int position.
  logic        rx_active;
  logic [6:0]  rx_seq;
  logic [7:0]  rx_cmd;
  int          rx_pos;
  logic [15:0] rx_crc;
  logic [7:0]  rx_delay [TRAILER];
  logic [7:0]  rx_soh;
  logic [7:0]  rx_stx;
  logic [7:0]  rx_echo;
  logic [7:0]  rx_number;
  logic [4:0]  rx_half;
  logic        rx_hex_bad;
  logic [13:0] rx_decoded;
  logic [14:0] rx_max_len;

  hapd_pkg::res_t pending_results[$];
  int   mismatches = 0;
  int   items_taken;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic sink_hold;
  event hold_sink;

  // -------------------------------------------------------------------------
  // Clock and run limit
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("hex_ascii_packet_deframer_crc16_top test failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Frame arithmetic
  // -------------------------------------------------------------------------
  // CRC-16 with the reflected polynomial, one octet, LSB first.
  function automatic logic [15:0] crc16_arc_update(input logic [15:0] crc,
                                                   input logic [7:0] octet);
    logic [15:0] acc;
    acc = crc ^ {8'h00, octet};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ hapd_pkg::CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  function automatic logic [7:0] nibble_to_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
  endfunction

  // Bit 4 flags an uppercase hex digit; low four bits hold its value.
  function automatic logic [4:0] char_to_nibble(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, ch[3:0]};
    if (ch >= 8'h41 && ch <= 8'h46) return {1'b1, ch[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // -------------------------------------------------------------------------
  // Receiver model
  // -------------------------------------------------------------------------
  function automatic void clear_rx_packet();
    rx_pos     = 0;
    rx_crc     = '0;
    rx_soh     = '0;
    rx_stx     = '0;
    rx_echo    = '0;
    rx_number  = '0;
    rx_half    = '0;
    rx_hex_bad = 1'b0;
    rx_decoded = '0;
    foreach (rx_delay[i]) rx_delay[i] = '0;
  endfunction

  // Judge a packet at its stop byte. Frame, then CRC, then number; a good
  // number advances even when the echo or the payload fails afterwards.
  function automatic hapd_pkg::status_t packet_status(input int len,
                                                      output logic [13:0] n_bytes);
    n_bytes = '0;
    if (len < hapd_pkg::MIN_FRAME_LEN || len > hapd_pkg::MAX_FRAME_LEN)
      return hapd_pkg::STATUS_FRAME;
    if (rx_soh != hapd_pkg::BYTE_SOH || rx_stx != hapd_pkg::BYTE_STX ||
        rx_delay[0] != hapd_pkg::BYTE_ETB)
      return hapd_pkg::STATUS_FRAME;
    if (rx_delay[1] != nibble_to_char(rx_crc[7:4]) ||
        rx_delay[2] != nibble_to_char(rx_crc[3:0]) ||
        rx_delay[3] != nibble_to_char(rx_crc[15:12]) ||
        rx_delay[4] != nibble_to_char(rx_crc[11:8]))
      return hapd_pkg::STATUS_CRC;
    if (rx_number != {1'b0, rx_seq}) return hapd_pkg::STATUS_SEQUENCE;
    rx_seq = (rx_seq == 7'h7F) ? hapd_pkg::SEQ_RESET : rx_seq + 7'd1;
    if ({1'b0, rx_cmd} + hapd_pkg::ECHO_FLAG != {1'b0, rx_echo})
      return hapd_pkg::STATUS_ECHO;
    if (rx_hex_bad || rx_decoded == '0) return hapd_pkg::STATUS_HEX;
    n_bytes = rx_decoded;
    return hapd_pkg::STATUS_OK;
  endfunction

  // Advance the model by one accepted item; return 1 when it yields a result.
  function automatic bit deframe_step(input hapd_pkg::op_t op, input logic [7:0] octet,
                                      output hapd_pkg::res_t res);
    int          pos;
    logic [7:0]  leaving;
    logic [4:0]  digit;
    logic [13:0] n_bytes;
    res = '0;
    if (op == hapd_pkg::OP_START) begin
      clear_rx_packet();
      rx_cmd    = octet;
      rx_active = 1'b1;
      return 1'b0;
    end
    if (!rx_active) return 1'b0;
    pos = rx_pos;
    if (octet == hapd_pkg::BYTE_ETX) begin
      res.kind          = hapd_pkg::KIND_END;
      res.status        = packet_status(pos + 1, n_bytes);
      res.payload_count = n_bytes;
      rx_active         = 1'b0;
      return 1'b1;
    end
    if (pos + 1 > int'(rx_max_len)) begin
      res.kind   = hapd_pkg::KIND_END;
      res.status = hapd_pkg::STATUS_OVERFLOW;
      rx_active  = 1'b0;
      return 1'b1;
    end
    rx_pos = pos + 1;
    case (pos)
      0: rx_soh = octet;
      1: begin
        rx_number = octet;
        rx_crc    = crc16_arc_update(rx_crc, octet);
      end
      2: rx_stx = octet;
      3: begin
        rx_echo = octet;
        rx_crc  = crc16_arc_update(rx_crc, octet);
      end
      default: begin
        // Payload reaches the decoder only once it leaves the trailer delay.
        leaving = rx_delay[0];
        for (int i = 0; i < TRAILER - 1; i++) rx_delay[i] = rx_delay[i + 1];
        rx_delay[TRAILER - 1] = octet;
        if (pos < 4 + TRAILER) return 1'b0;
        rx_crc = crc16_arc_update(rx_crc, leaving);
        if (rx_hex_bad) return 1'b0;
        digit = char_to_nibble(leaving);
        if (rx_half == 5'd0) begin
          rx_half = digit[4] ? digit : 5'd1;
          return 1'b0;
        end
        if (rx_half == 5'd1 || !digit[4]) begin
          rx_hex_bad = 1'b1;
          rx_half    = 5'd0;
          return 1'b0;
        end
        res.kind         = hapd_pkg::KIND_PAYLOAD;
        res.payload_byte = {rx_half[3:0], digit[3:0]};
        rx_half          = 5'd0;
        rx_decoded       = rx_decoded + 14'd1;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: receiver stalls and checking
  // -------------------------------------------------------------------------
  // Hold the receiver off for a counted stretch when a test asks for it.
  initial begin
    sink_hold = 1'b0;
    forever begin
      @(hold_sink);
      sink_hold = 1'b1;
      repeat (SINK_HOLD_CYCLES) @(negedge clk);
      sink_hold = 1'b0;
    end
  end

  // Drop ready at random, or hold it low while a stretch is requested.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin
    hapd_pkg::res_t want;
    hapd_pkg::res_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        $display("%0t: unexpected result kind %0d byte %02h status %0d count %0d",
                 $time, got.kind, got.payload_byte, got.status, got.payload_count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          $display({"%0t: result mismatch: expected kind %0d byte %02h status %0d ",
                    "count %0d, got kind %0d byte %02h status %0d count %0d"},
                   $time, want.kind, want.payload_byte, want.status, want.payload_count,
                   got.kind, got.payload_byte, got.status, got.payload_count);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Item side helpers
  // -------------------------------------------------------------------------
  // Offer one item, idling at random first; predict once the transaction
  // completes. Keep valid high between items so back-to-back offers stay
  // back to back.
  task automatic send_item(input hapd_pkg::op_t op, input logic [7:0] value);
    hapd_pkg::res_t res;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= {op, value};
    do @(posedge clk); while (!item_if.ready);
    if (op == hapd_pkg::OP_START || rx_active) items_taken++;
    if (deframe_step(op, value, res)) pending_results.push_back(res);
  endtask

  // Drop valid, let every predicted result arrive, then let the pipeline
  // settle, since a trailing byte may still be in flight with no result.
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write max_length only with the block idle.
  task automatic write_max_length(input logic [14:0] limit);
    wait_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= limit;
    do @(posedge clk); while (!cfg_if.ready);
    rx_max_len = limit;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void random_hex_text(input int n_pairs, output octet_q_t text);
    logic [7:0] v;
    text = {};
    repeat (n_pairs) begin
      v = 8'($urandom_range(255));
      text.push_back(nibble_to_char(v[7:4]));
      text.push_back(nibble_to_char(v[3:0]));
    end
  endfunction

  // Wrap a payload text: SOH, number, STX, echo, text, ETB, CRC chars, ETX.
  function automatic void make_frame(input logic [7:0] number, input logic [7:0] echo,
                                     input octet_q_t text, output octet_q_t frame);
    logic [15:0] crc;
    crc = crc16_arc_update(16'h0000, number);
    crc = crc16_arc_update(crc, echo);
    foreach (text[i]) crc = crc16_arc_update(crc, text[i]);
    frame = {hapd_pkg::BYTE_SOH, number, hapd_pkg::BYTE_STX, echo};
    foreach (text[i]) frame.push_back(text[i]);
    frame.push_back(hapd_pkg::BYTE_ETB);
    frame.push_back(nibble_to_char(crc[7:4]));
    frame.push_back(nibble_to_char(crc[3:0]));
    frame.push_back(nibble_to_char(crc[15:12]));
    frame.push_back(nibble_to_char(crc[11:8]));
    frame.push_back(hapd_pkg::BYTE_ETX);
  endfunction

  // Arm the receiver with a command, then stream the line bytes.
  task automatic send_frame(input logic [7:0] cmd, input octet_q_t frame);
    send_item(hapd_pkg::OP_START, cmd);
    foreach (frame[i]) send_item(hapd_pkg::OP_BYTE, frame[i]);
  endtask

  task automatic send_good_packet(input logic [7:0] cmd, input int n_pairs);
    octet_q_t text;
    octet_q_t frame;
    random_hex_text(n_pairs, text);
    make_frame({1'b0, rx_seq}, cmd + 8'h80, text, frame);
    send_frame(cmd, frame);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Line bytes with no exchange armed, and after a packet has ended, must
  // be swallowed without a result.
  task automatic test_idle_bytes();
    send_item(hapd_pkg::OP_BYTE, hapd_pkg::BYTE_SOH);
    send_item(hapd_pkg::OP_BYTE, hapd_pkg::BYTE_ETX);
    send_item(hapd_pkg::OP_BYTE, 8'hFF);
    send_item(hapd_pkg::OP_START, 8'h10);
    send_item(hapd_pkg::OP_BYTE, hapd_pkg::BYTE_ETX);
    send_item(hapd_pkg::OP_BYTE, 8'h00);
  endtask

  // Clean exchanges: payload extremes, odd tail character, restart.
  task automatic test_good_packets();
    octet_q_t text;
    octet_q_t frame;
    text = {8'h30, 8'h30, 8'h46, 8'h46};
    make_frame({1'b0, rx_seq}, 8'h80, text, frame);
    send_frame(8'h00, frame);
    // Drop the trailing unpaired character.
    text = {8'h41, 8'h35, 8'h42};
    make_frame({1'b0, rx_seq}, 8'hFF, text, frame);
    send_frame(8'h7F, frame);
    // Abandon a packet half way by arming again.
    send_item(hapd_pkg::OP_START, 8'h22);
    send_item(hapd_pkg::OP_BYTE, hapd_pkg::BYTE_SOH);
    send_item(hapd_pkg::OP_BYTE, {1'b0, rx_seq});
    send_good_packet(8'h33, 2);
  endtask

  // Packets for every failure kind but overflow, CRC first, framing last.
  task automatic test_status_codes();
    octet_q_t text;
    octet_q_t frame;
    random_hex_text(1, text);
    // Corrupt a CRC character; the number stays put.
    make_frame({1'b0, rx_seq}, 8'h85, text, frame);
    frame[frame.size() - 3] ^= 8'h01;
    send_frame(8'h05, frame);
    // CRC error outranks a wrong number.
    make_frame({1'b0, rx_seq} + 8'd1, 8'h85, text, frame);
    frame[frame.size() - 4] ^= 8'h01;
    send_frame(8'h05, frame);
    // Wrong number, then number zero.
    make_frame({1'b0, rx_seq} + 8'd1, 8'h85, text, frame);
    send_frame(8'h05, frame);
    make_frame(8'h00, 8'h85, text, frame);
    send_frame(8'h05, frame);
    // Wrong echo, then a command too large to ever echo.
    make_frame({1'b0, rx_seq}, 8'h86, text, frame);
    send_frame(8'h05, frame);
    make_frame({1'b0, rx_seq}, 8'h7F, text, frame);
    send_frame(8'hFF, frame);
    // Empty payload.
    text = {};
    make_frame({1'b0, rx_seq}, 8'h81, text, frame);
    send_frame(8'h01, frame);
    // Bad high character; bad low character followed by a good pair.
    text = {8'h67, 8'h30};
    make_frame({1'b0, rx_seq}, 8'h81, text, frame);
    send_frame(8'h01, frame);
    text = {8'h31, 8'h32, 8'h31, 8'h61, 8'h31, 8'h32};
    make_frame({1'b0, rx_seq}, 8'h81, text, frame);
    send_frame(8'h01, frame);
    // Broken framing bytes: ETB, SOH, STX.
    random_hex_text(1, text);
    make_frame({1'b0, rx_seq}, 8'h81, text, frame);
    frame[frame.size() - 6] = 8'h18;
    send_frame(8'h01, frame);
    make_frame({1'b0, rx_seq}, 8'h81, text, frame);
    frame[0] = 8'h00;
    send_frame(8'h01, frame);
    make_frame({1'b0, rx_seq}, 8'h81, text, frame);
    frame[2] = 8'hFF;
    send_frame(8'h01, frame);
    // Stop byte as the first byte, where the number belongs, mid payload.
    send_frame(8'h01, {hapd_pkg::BYTE_ETX});
    send_frame(8'h01, {hapd_pkg::BYTE_SOH, hapd_pkg::BYTE_ETX});
    send_frame(8'h01, {hapd_pkg::BYTE_SOH, {1'b0, rx_seq}, hapd_pkg::BYTE_STX, 8'h81,
                       8'h31, 8'h32, hapd_pkg::BYTE_ETX});
  endtask

  // Smallest max_length: overflow on the eleventh byte, while a ten-byte
  // frame still completes.
  task automatic test_length_limit();
    octet_q_t text;
    octet_q_t frame;
    write_max_length(15'd10);
    send_good_packet(8'h40, 1);
    text = {};
    make_frame({1'b0, rx_seq}, 8'hC0, text, frame);
    send_frame(8'h40, frame);
    send_good_packet(8'h40, 0);
    write_max_length(15'd40);
    send_good_packet(8'h41, 16);
  endtask

  function automatic traffic_t pick_traffic();
    int p;
    p = $urandom_range(99);
    if (p < 60) return TRAFFIC_GOOD;
    if (p < 72) return TRAFFIC_MUTATED;
    if (p < 78) return TRAFFIC_BAD_HEADER;
    if (p < 84) return TRAFFIC_TRUNCATED;
    if (p < 90) return TRAFFIC_BAD_TEXT;
    return TRAFFIC_NOISE;
  endfunction

  // Mostly well-formed exchanges with random content; the rest damaged
  // frames, cut-off frames and raw line noise.
  task automatic test_random_traffic(input int n_items);
    int         stop_at;
    int         n_pairs;
    traffic_t   flavor;
    logic [7:0] cmd;
    logic [7:0] number;
    octet_q_t   text;
    octet_q_t   frame;
    stop_at = items_taken + n_items;
    while (items_taken < stop_at) begin
      flavor  = pick_traffic();
      cmd     = 8'($urandom_range(127));
      number  = {1'b0, rx_seq};
      n_pairs = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
      random_hex_text(n_pairs, text);
      if ($urandom_range(5) == 0) text.push_back(nibble_to_char(4'($urandom_range(15))));
      if (flavor == TRAFFIC_NOISE) begin
        repeat ($urandom_range(1, 20))
          send_item(hapd_pkg::op_t'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        if (flavor == TRAFFIC_BAD_HEADER) begin
          if ($urandom_range(1)) cmd = 8'($urandom_range(128, 255));
          else number = 8'($urandom_range(255));
        end
        if (flavor == TRAFFIC_BAD_TEXT)
          foreach (text[i]) if ($urandom_range(3) == 0) text[i] = 8'($urandom_range(255));
        make_frame(number, cmd + 8'h80, text, frame);
        if (flavor == TRAFFIC_MUTATED)
          frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
        if (flavor == TRAFFIC_TRUNCATED)
          repeat ($urandom_range(1, 5)) frame.delete(frame.size() - 1);
        send_frame(cmd, frame);
      end
    end
  endtask

  // Hold the receiver off long enough for the result buffer to fill and
  // the item side to stall, while payload bytes keep coming.
  task automatic test_output_backpressure();
    -> hold_sink;
    send_good_packet(8'h2A, 40);
  endtask

  // -------------------------------------------------------------------------
  // Sequence of tests
  // -------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    item_if.valid    = 1'b0;
    item_if.data     = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    items_taken      = 0;
    send_idle_pct    = 32;
    recv_idle_pct    = 69;
    rx_active        = 1'b0;
    rx_seq           = hapd_pkg::SEQ_RESET;
    rx_cmd           = '0;
    rx_max_len       = hapd_pkg::MAX_LENGTH_RESET;
    clear_rx_packet();
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Phase one: sender idles now and then, receiver mostly stalls.
    test_idle_bytes();
    test_good_packets();
    test_status_codes();
    test_length_limit();
    test_random_traffic(RANDOM_ITEMS);

    // Phase two: the other way round, at the reset limit again.
    write_max_length(hapd_pkg::MAX_LENGTH_RESET);
    send_idle_pct = 69;
    recv_idle_pct = 32;
    test_random_traffic(RANDOM_ITEMS);

    // Phase three: no idling on either side.
    write_max_length(15'd32767);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS);
    test_output_backpressure();

    wait_idle();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("hex_ascii_packet_deframer_crc16_top test passed");
    end else begin
      $display("hex_ascii_packet_deframer_crc16_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/hapd_pkg.sv
rtl/hapd_stream_if.sv
rtl/hapd_frame_rx.sv
rtl/hapd_out_buf.sv
rtl/hex_ascii_packet_deframer_crc16_top.sv
verif/tb_hex_ascii_packet_deframer_crc16_top.sv
